// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the slab allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SCSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition implies another in the next cycle
`define SCSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    `SCSA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- src/scsa_pkg.sv -----
// Types and constants of the size-class slab allocator
`timescale 1ns / 1ps
package scsa_pkg;

    localparam int REQ_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int OPA_W      = 20;
    localparam int CLS_W      = 4;
    localparam int ST_W       = 3;
    localparam int BLK_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_CLS_SH = 6;
    localparam int CNT_W      = BLK_W - MIN_CLS_SH;
    localparam int SZ_W       = BLK_W + 1;

    localparam logic [BLK_W-1:0] HDR_BYTES   = BLK_W'(16);
    localparam logic [BLK_W-1:0] MIN_BLOCK   = BLK_W'(4 * 1024);
    localparam logic [BLK_W-1:0] DEF_BLOCK   = BLK_W'(64 * 1024);
    localparam logic [BLK_W-1:0] DEF_MAX     = BLK_W'(16384);
    localparam logic [SZ_W-1:0]  MIN_CLASS   = SZ_W'(64);
    localparam logic [CLS_W-1:0] NOT_CARVED  = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POOLED  = 2'd1;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 3'd0,
        ST_OVERSIZED   = 3'd1,
        ST_EXHAUSTED   = 3'd2,
        ST_TOO_SMALL   = 3'd3,
        ST_REL_DIRECT  = 3'd4,
        ST_REL_IGNORED = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        E_FAIL,
        E_POP,
        E_CARVE,
        E_REL
    } t_emit;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_POP,
        S_REL,
        S_CARVE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    clr_step;
        logic    pop_commit;
        logic    carve_init;
        logic    carve_step;
        logic    rel_push;
        logic    emit;
        t_emit   emit_sel;
        t_status fail_status;
    } t_dp_cmd;

    typedef struct packed {
        logic is_release;
        logic rel_direct;
        logic rel_ignore_early;
        logic rel_class_bad;
        logic oversized;
        logic nonempty;
        logic too_small;
        logic exhausted;
        logic carve_last;
        logic clr_last;
    } t_dp_sts;

endpackage

// ----- src/size_class_slab_allocator.sv -----
// Top level of the size-class slab allocator
// Flow: rejects and direct releases give their result from the evaluation state; pops
// and release pushes go on to their own state (a registered store read); a carve steps
// its state over the block's slots. No new item is taken before the last one's result;
// the next is taken as the result transfers. Reset: synchronous; a clearing pass then
// marks every granule uncarved, with busy high. Results strobe one cycle; no stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module size_class_slab_allocator #(
    parameter int ARENA_BYTES   = 1048576,
    parameter int CLASS_COUNT   = 9,
    parameter int GRANULE_BYTES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_opcode,
    input  logic [scsa_pkg::REQ_W-1:0]     i_request_bytes,
    input  logic [scsa_pkg::ADDR_W-1:0]    i_release_address,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [scsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [scsa_pkg::BLK_W-1:0]     i_cfg_data,
    output logic                           o_valid,
    output logic [scsa_pkg::ST_W-1:0]      o_status,
    output logic [scsa_pkg::OPA_W-1:0]     o_operation_address,
    output logic [scsa_pkg::CLS_W-1:0]     o_class_index
);

    scsa_pkg::t_dp_cmd cmd;
    scsa_pkg::t_dp_sts sts;

    // Take configuration transfers at any time
    assign o_cfg_ready = 1'b1;

    scsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    scsa_dp #(
        .ARENA_BYTES   (ARENA_BYTES),
        .CLASS_COUNT   (CLASS_COUNT),
        .GRANULE_BYTES (GRANULE_BYTES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_opcode            (i_opcode),
        .i_request_bytes     (i_request_bytes),
        .i_release_address   (i_release_address),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_operation_address (o_operation_address),
        .o_class_index       (o_class_index)
    );

    // An accepted item keeps the block busy and gives no result in the next cycle
    `SCSA_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy && !o_valid, "accept not held")
    // A failed result names no class
    `SCSA_ASSERT(a_fail_class, (o_valid && o_status != scsa_pkg::ST_OK) |-> (o_class_index == 4'(CLASS_COUNT)), "fail with class")
    // A granted result names a real class
    `SCSA_ASSERT(a_ok_class, (o_valid && o_status == scsa_pkg::ST_OK) |-> (o_class_index < 4'(CLASS_COUNT)), "ok without class")
    // A direct or ignored release result never carries an address
    `SCSA_ASSERT(a_rel_addr, (o_valid && (o_status == scsa_pkg::ST_REL_DIRECT || o_status == scsa_pkg::ST_REL_IGNORED)) |-> (o_operation_address == '0), "release address")

endmodule

// ----- src/scsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/scsa_ctrl.sv -----
// Controller state machine of the slab allocator
`timescale 1ns / 1ps
module scsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  scsa_pkg::t_dp_sts i_sts,
    output scsa_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);

    scsa_pkg::t_state r_state, n_state;

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scsa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Decide next state and issue datapath commands
    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.emit_sel     = scsa_pkg::E_FAIL;
        o_cmd.fail_status  = scsa_pkg::ST_OK;
        case (r_state)
            scsa_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = scsa_pkg::S_IDLE;
            end
            scsa_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = scsa_pkg::S_EVAL;
                end
            end
            scsa_pkg::S_EVAL: begin
                n_state = scsa_pkg::S_IDLE;
                if (i_sts.is_release) begin
                    if (i_sts.rel_direct) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.fail_status = scsa_pkg::ST_REL_DIRECT;
                    end else if (i_sts.rel_ignore_early) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.fail_status = scsa_pkg::ST_REL_IGNORED;
                    end else begin
                        n_state = scsa_pkg::S_REL;
                    end
                end else if (i_sts.oversized) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.fail_status = scsa_pkg::ST_OVERSIZED;
                end else if (i_sts.nonempty) begin
                    n_state = scsa_pkg::S_POP;
                end else if (i_sts.too_small) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.fail_status = scsa_pkg::ST_TOO_SMALL;
                end else if (i_sts.exhausted) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.fail_status = scsa_pkg::ST_EXHAUSTED;
                end else begin
                    o_cmd.carve_init = 1'b1;
                    n_state          = scsa_pkg::S_CARVE;
                end
            end
            scsa_pkg::S_POP: begin
                o_cmd.pop_commit = 1'b1;
                o_cmd.emit       = 1'b1;
                o_cmd.emit_sel   = scsa_pkg::E_POP;
                n_state          = scsa_pkg::S_IDLE;
            end
            scsa_pkg::S_REL: begin
                o_cmd.emit = 1'b1;
                n_state    = scsa_pkg::S_IDLE;
                if (i_sts.rel_class_bad) begin
                    o_cmd.fail_status = scsa_pkg::ST_REL_IGNORED;
                end else begin
                    o_cmd.rel_push = 1'b1;
                    o_cmd.emit_sel = scsa_pkg::E_REL;
                end
            end
            scsa_pkg::S_CARVE: begin
                o_cmd.carve_step = 1'b1;
                if (i_sts.carve_last) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = scsa_pkg::E_CARVE;
                    n_state        = scsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scsa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != scsa_pkg::S_IDLE);

endmodule

// ----- src/scsa_dp.sv -----
// Datapath of the slab allocator: config, free lists, memories, results
`timescale 1ns / 1ps
module scsa_dp #(
    parameter int ARENA_BYTES   = 1048576,
    parameter int CLASS_COUNT   = 9,
    parameter int GRANULE_BYTES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scsa_pkg::t_dp_cmd                i_cmd,
    output scsa_pkg::t_dp_sts                o_sts,
    input  logic                             i_opcode,
    input  logic [scsa_pkg::REQ_W-1:0]       i_request_bytes,
    input  logic [scsa_pkg::ADDR_W-1:0]      i_release_address,
    input  logic                             i_cfg_valid,
    input  logic [scsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [scsa_pkg::BLK_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    output logic [scsa_pkg::ST_W-1:0]        o_status,
    output logic [scsa_pkg::OPA_W-1:0]       o_operation_address,
    output logic [scsa_pkg::CLS_W-1:0]       o_class_index
);

    localparam int GCOUNT = ARENA_BYTES / GRANULE_BYTES;
    localparam int GW     = $clog2(GCOUNT);
    localparam int GSH    = $clog2(GRANULE_BYTES);
    localparam int LW     = GW + 1;
    localparam int FW     = $clog2(ARENA_BYTES) + 1;
    localparam int CMPW   = ((FW > scsa_pkg::SZ_W) ? FW : scsa_pkg::SZ_W) + 1;
    localparam logic [scsa_pkg::CLS_W-1:0] CLS_NONE = scsa_pkg::CLS_W'(CLASS_COUNT);
    localparam logic [FW-1:0] GMASK = FW'(GRANULE_BYTES - 1);

    // Configuration and latched item
    logic [scsa_pkg::BLK_W-1:0]  r_block, r_max;
    logic                        r_op;
    logic [scsa_pkg::REQ_W-1:0]  r_req;
    logic [scsa_pkg::ADDR_W-1:0] r_addr;

    // Free lists and carve state
    logic [GW-1:0]               r_head [CLASS_COUNT];
    logic [CLASS_COUNT-1:0]      r_nonempty;
    logic [FW-1:0]               r_fill, r_start, r_base;
    logic [scsa_pkg::CNT_W-1:0]  r_rem;
    logic                        r_first;
    logic [GW-1:0]               r_pop_g, r_clr_cnt;

    // Result registers
    logic                        r_valid;
    scsa_pkg::t_status           r_status;
    logic [scsa_pkg::OPA_W-1:0]  r_opa;
    logic [scsa_pkg::CLS_W-1:0]  r_cls_out;

    // Decode signals
    logic [scsa_pkg::BLK_W-1:0]  total;
    logic                        found;
    logic [scsa_pkg::CLS_W-1:0]  cls;
    logic [4:0]                  slot_sh;
    logic [scsa_pkg::BLK_W-1:0]  sc_full, used;
    logic [scsa_pkg::SZ_W-1:0]   slot_bytes;
    logic [FW-1:0]               base;
    logic [scsa_pkg::ADDR_W-1:0] rel_off;
    logic [GW-1:0]               rel_g, carve_g, push_g;
    logic [scsa_pkg::CLS_W-1:0]  class_rdata, class_wdata, rel_cls, push_cls;
    logic                        class_we, aligned, push_en;
    logic [GW-1:0]               class_waddr;
    logic [LW-1:0]               link_rdata, link_wdata;
    logic [FW-1:0]               pop_full, carve_full;

    // Pick the smallest class that holds request plus header
    always_comb begin
        total = scsa_pkg::BLK_W'(r_req) + scsa_pkg::HDR_BYTES;
        found = 1'b0;
        cls   = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if ((scsa_pkg::MIN_CLASS << c) >= scsa_pkg::SZ_W'(total)) begin
                found = 1'b1;
                cls   = scsa_pkg::CLS_W'(c);
            end
        end
    end

    // Block geometry for the chosen class
    assign slot_sh    = 5'(cls) + 5'(scsa_pkg::MIN_CLS_SH);
    assign sc_full    = r_block >> slot_sh;
    assign used       = sc_full << slot_sh;
    assign slot_bytes = scsa_pkg::MIN_CLASS << cls;
    assign base       = (r_fill + GMASK) & ~GMASK;

    // Release address decode
    assign rel_off = r_addr - scsa_pkg::ADDR_W'(scsa_pkg::HDR_BYTES);
    assign rel_g   = rel_off[GSH +: GW];
    assign rel_cls = class_rdata;

    // Status toward the controller
    always_comb begin
        o_sts                  = '0;
        o_sts.is_release       = r_op;
        o_sts.rel_direct       = (r_addr >= scsa_pkg::ADDR_W'(ARENA_BYTES));
        o_sts.rel_ignore_early = (r_addr < scsa_pkg::ADDR_W'(scsa_pkg::HDR_BYTES)) ||
                                 ((rel_off & scsa_pkg::ADDR_W'(GRANULE_BYTES - 1)) != '0);
        o_sts.rel_class_bad    = (rel_cls >= CLS_NONE);
        o_sts.oversized        = (total > r_max) || !found;
        o_sts.nonempty         = r_nonempty[cls];
        o_sts.too_small        = (sc_full == '0);
        o_sts.exhausted        = (CMPW'(base) > CMPW'(ARENA_BYTES)) ||
                                 (CMPW'(used) + CMPW'(base) > CMPW'(ARENA_BYTES));
        o_sts.carve_last       = (r_rem == scsa_pkg::CNT_W'(1));
        o_sts.clr_last         = (r_clr_cnt == '1);
    end

    // Carve slot placement
    assign aligned = ((r_start & GMASK) == '0);
    assign carve_g = r_start[GSH +: GW];

    // Class store writes: clearing pass or carve
    always_comb begin
        class_we    = i_cmd.clr_step || (i_cmd.carve_step && aligned);
        class_waddr = i_cmd.clr_step ? r_clr_cnt : carve_g;
        class_wdata = i_cmd.clr_step ? scsa_pkg::NOT_CARVED : cls;
    end

    // Push onto a free list from carve or release
    always_comb begin
        push_en    = (i_cmd.carve_step && aligned && !r_first) || i_cmd.rel_push;
        push_cls   = i_cmd.rel_push ? rel_cls : cls;
        push_g     = i_cmd.rel_push ? rel_g : carve_g;
        link_wdata = r_nonempty[push_cls] ? (LW'(r_head[push_cls]) + LW'(1)) : '0;
    end

    scsa_ram #(.WIDTH(scsa_pkg::CLS_W), .DEPTH(GCOUNT)) u_class_ram (
        .i_clk   (i_clk),
        .i_we    (class_we),
        .i_waddr (class_waddr),
        .i_wdata (class_wdata),
        .i_raddr (rel_g),
        .o_rdata (class_rdata)
    );

    scsa_ram #(.WIDTH(LW), .DEPTH(GCOUNT)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (push_en),
        .i_waddr (push_g),
        .i_wdata (link_wdata),
        .i_raddr (r_head[cls]),
        .o_rdata (link_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block <= scsa_pkg::DEF_BLOCK;
            r_max   <= scsa_pkg::DEF_MAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                scsa_pkg::CFG_BLOCK_BYTES: begin
                    r_block <= (i_cfg_data < scsa_pkg::MIN_BLOCK) ? scsa_pkg::MIN_BLOCK
                                                                  : i_cfg_data;
                end
                scsa_pkg::CFG_MAX_POOLED: begin
                    r_max <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Latch the item, the carve bookkeeping and the granule to pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_req  <= i_request_bytes;
            r_addr <= i_release_address;
        end
        if (i_cmd.carve_init) begin
            r_start <= base;
            r_base  <= base;
            r_rem   <= sc_full[scsa_pkg::CNT_W-1:0];
            r_first <= 1'b1;
        end else if (i_cmd.carve_step) begin
            r_start <= r_start + FW'(slot_bytes);
            r_rem   <= r_rem - scsa_pkg::CNT_W'(1);
            r_first <= 1'b0;
        end
        if (o_sts.nonempty) begin
            r_pop_g <= r_head[cls];
        end
    end

    // Free list heads, arena fill and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_head[c] <= '0;
            end
            r_nonempty <= '0;
            r_fill     <= '0;
            r_clr_cnt  <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + GW'(1);
            end
            if (push_en) begin
                r_head[push_cls]     <= push_g;
                r_nonempty[push_cls] <= 1'b1;
            end
            if (i_cmd.pop_commit) begin
                if (link_rdata == '0) begin
                    r_nonempty[cls] <= 1'b0;
                end else begin
                    r_head[cls] <= GW'(link_rdata - LW'(1));
                end
            end
            if (i_cmd.carve_step && o_sts.carve_last) begin
                r_fill <= r_base + FW'(used);
            end
        end
    end

    // Result addresses
    assign pop_full   = (FW'(r_pop_g) << GSH) + FW'(scsa_pkg::HDR_BYTES);
    assign carve_full = r_base + FW'(scsa_pkg::HDR_BYTES);

    // Result register: one strobe per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            case (i_cmd.emit_sel)
                scsa_pkg::E_POP: begin
                    r_status  <= scsa_pkg::ST_OK;
                    r_opa     <= scsa_pkg::OPA_W'(pop_full);
                    r_cls_out <= cls;
                end
                scsa_pkg::E_CARVE: begin
                    r_status  <= scsa_pkg::ST_OK;
                    r_opa     <= scsa_pkg::OPA_W'(carve_full);
                    r_cls_out <= cls;
                end
                scsa_pkg::E_REL: begin
                    r_status  <= scsa_pkg::ST_OK;
                    r_opa     <= '0;
                    r_cls_out <= rel_cls;
                end
                default: begin
                    r_status  <= i_cmd.fail_status;
                    r_opa     <= '0;
                    r_cls_out <= CLS_NONE;
                end
            endcase
        end
    end

    assign o_valid             = r_valid;
    assign o_status            = r_status;
    assign o_operation_address = r_opa;
    assign o_class_index       = r_cls_out;

endmodule
